// ===== hdl/rbes_pkg.sv =====
// shared types and constants for the rtc calendar to elapsed seconds converter
package rbes_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned DnW      = 17;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_YEAR   = 3'd0,
    CFG_REF_MONTH  = 3'd1,
    CFG_REF_DAY    = 3'd2,
    CFG_BCD_MODE   = 3'd3,
    CFG_DST_ENABLE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0] ref_year;
    logic [3:0] ref_month;
    logic [4:0] ref_day;
    logic       bcd_mode;
    logic       dst_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] seconds_byte;
    logic [7:0] minutes_byte;
    logic [7:0] hours_byte;
    logic [7:0] date_byte;
    logic [7:0] month_byte;
    logic [7:0] year_byte;
  } in_word_t;

  typedef enum logic [1:0] {
    DN_REF  = 2'd0,
    DN_READ = 2'd1,
    DN_LAST = 2'd2
  } dn_sel_e;

  typedef struct packed {
    logic    load;
    logic    dn_en;
    dn_sel_e dn_sel;
    logic    wday_en;
    logic    dst_en;
    logic    mul_en;
    logic    sum_en;
  } dp_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_sts_t;

endpackage

// ===== hdl/rbes_if.sv =====
// word channels for the converter: one reading in, one result out
interface rbes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] seconds_byte;
  logic [7:0] minutes_byte;
  logic [7:0] hours_byte;
  logic [7:0] date_byte;
  logic [7:0] month_byte;
  logic [7:0] year_byte;

  modport source (
    output valid, seconds_byte, minutes_byte, hours_byte, date_byte, month_byte, year_byte,
    input  ready
  );
  modport sink (
    input  valid, seconds_byte, minutes_byte, hours_byte, date_byte, month_byte, year_byte,
    output ready
  );
endinterface

interface rbes_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] elapsed_seconds;
  logic        before_reference;

  modport source (
    output valid, elapsed_seconds, before_reference,
    input  ready
  );
  modport sink (
    input  valid, elapsed_seconds, before_reference,
    output ready
  );
endinterface

// ===== hdl/rbes_cfg.sv =====
// configuration register file
module rbes_cfg import rbes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REF_YEAR:   cfg_d.ref_year   = cfg_wdata_i[6:0];
        CFG_REF_MONTH:  cfg_d.ref_month  = cfg_wdata_i[3:0];
        CFG_REF_DAY:    cfg_d.ref_day    = cfg_wdata_i[4:0];
        CFG_BCD_MODE:   cfg_d.bcd_mode   = cfg_wdata_i[0];
        CFG_DST_ENABLE: cfg_d.dst_enable = cfg_wdata_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_year   <= 7'd0;
      cfg_q.ref_month  <= 4'd1;
      cfg_q.ref_day    <= 5'd1;
      cfg_q.bcd_mode   <= 1'b1;
      cfg_q.dst_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/rbes_dp.sv =====
// datapath: byte decode, shared day-number unit, weekday, summer time and seconds sum
module rbes_dp import rbes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  cfg_t        cfg_i,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] elapsed_seconds_o,
  output logic        before_reference_o
);

  localparam logic [34:0] Recip7 = 35'd149797; // ceil(2^20 / 7)

  function automatic logic [7:0] decode(input logic [7:0] b, input logic bcd);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'b0, b[7:4]};
    lo = {4'b0, b[3:0]};
    return bcd ? 8'((hi << 3) + (hi << 1) + lo) : b;
  endfunction

  // 2000 + k for k below 256: only 2100 and 2200 break the four-year rule
  function automatic logic is_leap(input logic [7:0] k);
    return (k[1:0] == 2'b00) && (k != 8'd100) && (k != 8'd200);
  endfunction

  function automatic logic [6:0] leaps_before(input logic [7:0] y);
    logic [8:0] y3;
    y3 = {1'b0, y} + 9'd3;
    return y3[8:2] - 7'(y > 8'd100) - 7'(y > 8'd200);
  endfunction

  // days before month m; month 0 starts the year, months past 12 are 31 days
  function automatic logic [12:0] cum_days(input logic [7:0] m, input logic leap);
    logic [12:0] base;
    logic [12:0] mx;
    mx = 13'(m) - 13'd13;
    case (m)
      8'd0, 8'd1: base = 13'd0;
      8'd2:       base = 13'd31;
      8'd3:       base = 13'd59;
      8'd4:       base = 13'd90;
      8'd5:       base = 13'd120;
      8'd6:       base = 13'd151;
      8'd7:       base = 13'd181;
      8'd8:       base = 13'd212;
      8'd9:       base = 13'd243;
      8'd10:      base = 13'd273;
      8'd11:      base = 13'd304;
      8'd12:      base = 13'd334;
      8'd13:      base = 13'd365;
      default:    base = 13'd365 + (mx << 5) - mx;
    endcase
    return base + 13'(leap && (m >= 8'd3));
  endfunction

  logic [7:0] sec_q, min_q, hr_q, day_q, mon_q, yr_q;
  logic [DnW-1:0] dn_ref_q, dn_rd_q, dn_ls_q;
  logic [14:0] quot_q;
  logic        dst_q;
  logic signed [35:0] prod_q;
  logic signed [20:0] hms_q;
  logic        out_valid_q;
  logic [31:0] elapsed_q;
  logic        before_q;

  // shared day-number unit
  logic [7:0] op_y, op_m, op_d;
  logic [DnW-1:0] dn;

  always_comb begin
    case (cmd_i.dn_sel)
      DN_REF: begin
        op_y = {1'b0, cfg_i.ref_year};
        op_m = {4'b0, cfg_i.ref_month};
        op_d = {3'b0, cfg_i.ref_day};
      end
      DN_LAST: begin
        op_y = yr_q;
        op_m = mon_q;
        op_d = 8'd31;
      end
      default: begin
        op_y = yr_q;
        op_m = mon_q;
        op_d = day_q;
      end
    endcase
    dn = 17'({9'b0, op_y} * 17'd365) + 17'(leaps_before(op_y))
       + 17'(cum_days(op_m, is_leap(op_y))) + 17'(op_d);
  end

  // weekday of the month's 31st, 2000-01-01 being a saturday
  logic [DnW-1:0] wx;
  logic [34:0]    wprod;
  logic [DnW-1:0] wrem;
  logic [4:0]     last_sun;
  logic [7:0]     ls8;
  logic           summer;

  always_comb begin
    wx       = dn_ls_q + 17'd5;
    wprod    = {18'b0, wx} * Recip7;
    wrem     = wx - 17'({2'b0, quot_q} * 17'd7);
    last_sun = 5'd31 - {2'b0, wrem[2:0]};
    ls8      = {3'b0, last_sun};
    summer   = ((mon_q > 8'd3) && (mon_q < 8'd10))
            || ((mon_q == 8'd3)
                && ((day_q > ls8) || ((day_q == ls8) && (hr_q >= 8'd2))))
            || ((mon_q == 8'd10)
                && ((day_q < ls8) || ((day_q == ls8) && (hr_q < 8'd3))));
  end

  logic signed [17:0] days;
  logic [19:0]        hms_u;
  logic [36:0]        total;
  logic               sat;

  always_comb begin
    days  = $signed({1'b0, dn_rd_q}) - $signed({1'b0, dn_ref_q});
    hms_u = 20'(hr_q) * 20'd3600 + 20'(min_q) * 20'd60 + 20'(sec_q);
    total = {prod_q[35], prod_q} + {{16{hms_q[20]}}, hms_q};
    sat   = !total[36] && (|total[35:32]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sec_q <= decode(in_word_i.seconds_byte, cfg_i.bcd_mode);
      min_q <= decode(in_word_i.minutes_byte, cfg_i.bcd_mode);
      hr_q  <= decode(in_word_i.hours_byte, cfg_i.bcd_mode);
      day_q <= decode(in_word_i.date_byte, cfg_i.bcd_mode);
      mon_q <= decode(in_word_i.month_byte, cfg_i.bcd_mode);
      yr_q  <= decode(in_word_i.year_byte, cfg_i.bcd_mode);
    end
    if (cmd_i.dn_en) begin
      case (cmd_i.dn_sel)
        DN_REF:  dn_ref_q <= dn;
        DN_READ: dn_rd_q  <= dn;
        DN_LAST: dn_ls_q  <= dn;
        default: dn_rd_q  <= dn;
      endcase
    end
    if (cmd_i.wday_en) begin
      quot_q <= wprod[34:20];
    end
    if (cmd_i.dst_en) begin
      dst_q <= cfg_i.dst_enable && summer;
    end
    if (cmd_i.mul_en) begin
      prod_q <= days * 18'sd86400;
      hms_q  <= $signed({1'b0, hms_u}) - (dst_q ? 21'sd3600 : 21'sd0);
    end
    if (cmd_i.sum_en) begin
      before_q  <= total[36];
      elapsed_q <= total[36] ? 32'd0 : (sat ? 32'hFFFF_FFFF : total[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.sum_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_stall    = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign elapsed_seconds_o  = elapsed_q;
  assign before_reference_o = before_q;

endmodule

// ===== hdl/rbes_ctrl.sv =====
// sequencer stepping one reading through the datapath
module rbes_ctrl import rbes_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DN_REF,
    ST_DN_READ,
    ST_DN_LAST,
    ST_WDAY,
    ST_DST,
    ST_MUL,
    ST_SUM
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q <= ST_DN_REF;
            ready_q <= 1'b0;
          end
        end
        ST_DN_REF:  state_q <= ST_DN_READ;
        ST_DN_READ: state_q <= ST_DN_LAST;
        ST_DN_LAST: state_q <= ST_WDAY;
        ST_WDAY:    state_q <= ST_DST;
        ST_DST:     state_q <= ST_MUL;
        ST_MUL:     state_q <= ST_SUM;
        ST_SUM: begin
          // hold until the output register is free
          if (!sts_i.out_stall) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.dn_sel = DN_READ;
    case (state_q)
      ST_IDLE:    cmd_o.load = in_valid_i && ready_q;
      ST_DN_REF: begin
        cmd_o.dn_en  = 1'b1;
        cmd_o.dn_sel = DN_REF;
      end
      ST_DN_READ: cmd_o.dn_en = 1'b1;
      ST_DN_LAST: begin
        cmd_o.dn_en  = 1'b1;
        cmd_o.dn_sel = DN_LAST;
      end
      ST_WDAY:    cmd_o.wday_en = 1'b1;
      ST_DST:     cmd_o.dst_en = 1'b1;
      ST_MUL:     cmd_o.mul_en = 1'b1;
      ST_SUM:     cmd_o.sum_en = !sts_i.out_stall;
      default:    cmd_o.load = 1'b0;
    endcase
  end

  assign in_ready_o = ready_q;

endmodule

// ===== hdl/rtc_bcd_to_elapsed_seconds_top.sv =====
// Converts one RTC calendar reading (BCD or binary bytes, years 2000 onwards) into the
// seconds elapsed since the configured reference date, removing one hour in European
// summer time when enabled; readings before the reference give zero with a flag, and
// results beyond 32 bits saturate. A new word is taken only after the last one is done:
// a fixed sequence of seven steps runs each reading through one shared
// day-number unit (reference date, reading, last day of the month for the weekday),
// then a weekday, summer-time, multiply and sum step. The result is written to the output
// register in the sum step, which waits while a stalled output still holds the last result.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle.
module rtc_bcd_to_elapsed_seconds_top import rbes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  rbes_in_if.sink             in_i,
  rbes_out_if.source          out_o
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  in_word_t in_word;

  assign in_word.seconds_byte = in_i.seconds_byte;
  assign in_word.minutes_byte = in_i.minutes_byte;
  assign in_word.hours_byte   = in_i.hours_byte;
  assign in_word.date_byte    = in_i.date_byte;
  assign in_word.month_byte   = in_i.month_byte;
  assign in_word.year_byte    = in_i.year_byte;

  rbes_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rbes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rbes_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_i              (cfg),
    .in_word_i          (in_word),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .elapsed_seconds_o  (out_o.elapsed_seconds),
    .before_reference_o (out_o.before_reference)
  );

endmodule

// ===== hdl/rbes_checker.sv =====
// port-level checks on the converter, bound to the top level
module rbes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] elapsed_seconds_i,
  input logic        before_reference_i
);

  // a reading before the reference always reports zero seconds
  a_before_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && before_reference_i |-> elapsed_seconds_i == 32'd0)
    else $error("before_reference result with nonzero seconds");

  // one reading in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word accepted while busy");

  // a new result only comes out of a busy converter
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a word being processed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(elapsed_seconds_i)
      && $stable(before_reference_i))
    else $error("stalled result changed");

endmodule

bind rtc_bcd_to_elapsed_seconds_top rbes_checker u_rbes_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .elapsed_seconds_i  (out_o.elapsed_seconds),
  .before_reference_i (out_o.before_reference)
);
